// ----- rtl/tlsq_pkg.sv -----
`default_nettype none

package tlsq_pkg;

    // Status of the signal head
    typedef enum logic [1:0] {
        PH_BLACK = 2'd0,
        PH_RED   = 2'd1,
        PH_GREEN = 2'd2
    } t_phase;

    // Register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_ON_QUALIFY  = 3'd0,
        REG_OFF_QUALIFY = 3'd1,
        REG_CONFIRM     = 3'd2,
        REG_GAP         = 3'd3,
        REG_BLACK_TMO   = 3'd4
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Reset values of the registers
    localparam logic [15:0] ON_QUALIFY_RST  = 16'd5;
    localparam logic [15:0] OFF_QUALIFY_RST = 16'd5;
    localparam logic [7:0]  CONFIRM_RST     = 8'd3;
    localparam logic [15:0] GAP_RST         = 16'd10;
    localparam logic [15:0] BLACK_TMO_RST   = 16'd1000;

    // Both lamps dark (sense is active low)
    localparam logic [1:0] STABLE_RST = 2'b11;

    typedef struct packed {
        logic [15:0] on_qualify_ticks;
        logic [15:0] off_qualify_ticks;
        logic [7:0]  confirm_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] black_timeout_ticks;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic   red_on;
        logic   green_on;
        t_phase phase;
        logic   phase_changed;
        logic   green_flashing;
        logic   had_green_flash;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/tlsq_debounce.sv -----
`default_nettype none

// Debounce for one active-low lamp sense line, separate on and off times
module tlsq_debounce (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic        i_raw,
    input  wire logic [15:0] i_on_ticks,
    input  wire logic [15:0] i_off_ticks,
    output logic             o_stable_next
);

    logic        r_stable;
    logic        n_stable;
    logic [15:0] r_count;
    logic [15:0] n_count;
    logic [15:0] count_inc;
    logic [15:0] limit;

    // Count while the raw level differs; flip once the limit is reached
    always_comb begin
        count_inc = r_count + 16'd1;
        limit     = r_stable ? i_on_ticks : i_off_ticks;
        n_stable  = r_stable;
        n_count   = '0;
        if (i_raw != r_stable) begin
            if (count_inc >= limit) begin
                n_stable = ~r_stable;
            end else begin
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_count  <= '0;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end

    assign o_stable_next = n_stable;

endmodule

`default_nettype wire

// ----- rtl/tlsq_phase.sv -----
`default_nettype none

// Status machine: confirm counter, dark timeout and green flash tracking
module tlsq_phase (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic             i_red,
    input  wire logic             i_green,
    input  wire tlsq_pkg::t_cfg   i_cfg,
    output tlsq_pkg::t_result     o_result
);

    tlsq_pkg::t_phase r_phase;
    tlsq_pkg::t_phase n_phase;
    logic [7:0]       r_confirm;
    logic [7:0]       n_confirm;
    logic [15:0]      r_dark;
    logic [15:0]      n_dark;
    logic             r_green_started;
    logic             n_green_started;
    logic             r_gap_seen;
    logic             n_gap_seen;
    logic             r_flash;
    logic             n_flash;
    logic             r_had_flash;
    logic             n_had_flash;
    logic             changed;
    logic             leave;
    logic [7:0]       confirm_inc;
    logic [15:0]      dark_inc;

    // Next state
    always_comb begin
        n_phase         = r_phase;
        n_confirm       = r_confirm;
        n_dark          = r_dark;
        n_green_started = r_green_started;
        n_gap_seen      = r_gap_seen;
        n_flash         = r_flash;
        n_had_flash     = r_had_flash;
        changed         = 1'b0;
        leave           = 1'b0;
        confirm_inc     = r_confirm + 8'd1;
        dark_inc        = r_dark + 16'd1;

        if (i_red && !i_green) begin
            if (r_phase != tlsq_pkg::PH_RED) begin
                n_confirm = confirm_inc;
                if (confirm_inc > i_cfg.confirm_ticks) begin
                    n_confirm = '0;
                    changed   = 1'b1;
                    n_phase   = tlsq_pkg::PH_RED;
                    leave     = 1'b1;
                end
            end
            n_dark = '0;
        end else if (i_green && !i_red) begin
            if (r_phase != tlsq_pkg::PH_GREEN) begin
                n_confirm = confirm_inc;
                if (confirm_inc > i_cfg.confirm_ticks) begin
                    n_confirm       = '0;
                    changed         = 1'b1;
                    n_phase         = tlsq_pkg::PH_GREEN;
                    n_green_started = 1'b1;
                    n_gap_seen      = 1'b0;
                end
            end else if (r_gap_seen) begin
                // green back after a long gap: flashing
                n_gap_seen = 1'b0;
                if (r_green_started) begin
                    n_green_started = 1'b0;
                    n_flash         = 1'b1;
                    n_had_flash     = 1'b1;
                end
            end
            n_dark = '0;
        end else if (!i_red && !i_green) begin
            n_dark = dark_inc;
            if (dark_inc > i_cfg.gap_ticks) begin
                if (r_phase == tlsq_pkg::PH_GREEN) begin
                    n_gap_seen = 1'b1;
                end
                if (dark_inc == i_cfg.black_timeout_ticks) begin
                    n_dark    = '0;
                    n_confirm = '0;
                    changed   = 1'b1;
                    n_phase   = tlsq_pkg::PH_BLACK;
                    leave     = 1'b1;
                end
            end
        end

        // leaving a phase clears the live flag first, the history flag next time
        if (leave) begin
            if (r_flash) begin
                n_flash = 1'b0;
            end else begin
                n_had_flash = 1'b0;
            end
        end
    end

    // Outputs
    always_comb begin
        o_result.red_on          = i_red;
        o_result.green_on        = i_green;
        o_result.phase           = n_phase;
        o_result.phase_changed   = changed;
        o_result.green_flashing  = n_flash;
        o_result.had_green_flash = n_had_flash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= tlsq_pkg::PH_BLACK;
            r_confirm       <= '0;
            r_dark          <= '0;
            r_green_started <= 1'b0;
            r_gap_seen      <= 1'b0;
            r_flash         <= 1'b0;
            r_had_flash     <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_confirm       <= n_confirm;
            r_dark          <= n_dark;
            r_green_started <= n_green_started;
            r_gap_seen      <= n_gap_seen;
            r_flash         <= n_flash;
            r_had_flash     <= n_had_flash;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/traffic_lamp_state_qualifier_top.sv -----
// Traffic lamp state qualifier. Each input beat is one sense tick carrying the
// two active-low lamp lines (bit 0 red, bit 1 green); every tick yields exactly
// one result beat with the debounced lamps, the black/red/green status, a
// change pulse and the green flash flags. A tick is taken every clock cycle
// while input stall is low: the debouncers and status machine update in the
// cycle the beat is accepted and the result is registered, with one skid entry
// so one more tick is accepted while the output is stalled; input stall rises
// only when that skid entry is occupied. Timing registers are written over the
// APB port at byte address 4*i and should be changed only while no ticks are in
// flight.
`default_nettype none

module traffic_lamp_state_qualifier_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_raw_lamps,
    // result output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_red_on,
    output logic                               o_green_on,
    output logic [1:0]                         o_phase,
    output logic                               o_phase_changed,
    output logic                               o_green_flashing,
    output logic                               o_had_green_flash,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tlsq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tlsq_pkg::DATA_W-1:0]   pwdata,
    output logic [tlsq_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    tlsq_pkg::t_cfg    r_cfg;
    tlsq_pkg::t_result result_next;
    tlsq_pkg::t_result r_out;
    tlsq_pkg::t_result r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              step;
    logic              out_take;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic [1:0]        stable_next;

    assign step     = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign wr_en    = psel && penable && pwrite;
    assign reg_idx  = paddr[tlsq_pkg::ADDR_W-1:2];
    assign pready   = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_qualify_ticks    <= tlsq_pkg::ON_QUALIFY_RST;
            r_cfg.off_qualify_ticks   <= tlsq_pkg::OFF_QUALIFY_RST;
            r_cfg.confirm_ticks       <= tlsq_pkg::CONFIRM_RST;
            r_cfg.gap_ticks           <= tlsq_pkg::GAP_RST;
            r_cfg.black_timeout_ticks <= tlsq_pkg::BLACK_TMO_RST;
        end else if (wr_en) begin
            case (reg_idx)
                tlsq_pkg::REG_ON_QUALIFY:  r_cfg.on_qualify_ticks    <= pwdata[15:0];
                tlsq_pkg::REG_OFF_QUALIFY: r_cfg.off_qualify_ticks   <= pwdata[15:0];
                tlsq_pkg::REG_CONFIRM:     r_cfg.confirm_ticks       <= pwdata[7:0];
                tlsq_pkg::REG_GAP:         r_cfg.gap_ticks           <= pwdata[15:0];
                tlsq_pkg::REG_BLACK_TMO:   r_cfg.black_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            tlsq_pkg::REG_ON_QUALIFY:  prdata = {16'd0, r_cfg.on_qualify_ticks};
            tlsq_pkg::REG_OFF_QUALIFY: prdata = {16'd0, r_cfg.off_qualify_ticks};
            tlsq_pkg::REG_CONFIRM:     prdata = {24'd0, r_cfg.confirm_ticks};
            tlsq_pkg::REG_GAP:         prdata = {16'd0, r_cfg.gap_ticks};
            tlsq_pkg::REG_BLACK_TMO:   prdata = {16'd0, r_cfg.black_timeout_ticks};
            default:                   prdata = '0;
        endcase
    end

    // Per-lamp debounce
    tlsq_debounce u_deb_red (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_raw         (i_raw_lamps[0]),
        .i_on_ticks    (r_cfg.on_qualify_ticks),
        .i_off_ticks   (r_cfg.off_qualify_ticks),
        .o_stable_next (stable_next[0])
    );

    tlsq_debounce u_deb_green (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_raw         (i_raw_lamps[1]),
        .i_on_ticks    (r_cfg.on_qualify_ticks),
        .i_off_ticks   (r_cfg.off_qualify_ticks),
        .o_stable_next (stable_next[1])
    );

    // Status machine
    tlsq_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_red    (!stable_next[0]),
        .i_green  (!stable_next[1]),
        .i_cfg    (r_cfg),
        .o_result (result_next)
    );

    // Result register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || step;
            r_skid_valid <= 1'b0;
        end else if (step) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : result_next;
        end else if (step) begin
            r_skid <= result_next;
        end
    end

    assign o_in_stall        = r_skid_valid;
    assign o_out_valid       = r_out_valid;
    assign o_red_on          = r_out.red_on;
    assign o_green_on        = r_out.green_on;
    assign o_phase           = r_out.phase;
    assign o_phase_changed   = r_out.phase_changed;
    assign o_green_flashing  = r_out.green_flashing;
    assign o_had_green_flash = r_out.had_green_flash;

endmodule

`default_nettype wire
